FILE: sv/tlps_pkg.sv
`default_nettype none
package tlps_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DUR_W           = 16;
  localparam int PRESC_W         = 16;

  typedef enum logic {
    MODE_PUSH = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef struct packed {
    logic             level;
    logic [DUR_W-1:0] duration;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

FILE: sv/tlps_entry_ram.sv
`default_nettype none
module tlps_entry_ram
  import tlps_pkg::*;
#(
  parameter int DEPTH  = QUEUE_DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire entry_t            wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output entry_t                 rd_data_r
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // write-to-read forwarding keeps the head word current
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/tlps_out_buf.sv
`default_nettype none
module tlps_out_buf #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [WIDTH-1:0]      out_data
);

  logic             out_v_r, out_v_nxt;
  logic [WIDTH-1:0] out_d_r, out_d_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [WIDTH-1:0] skid_d_r, skid_d_nxt;

  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (out_v_r && out_stall) begin
      if (in_valid && !skid_v_r) begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = in_data;
      end
    end else if (skid_v_r) begin
      out_v_nxt  = 1'b1;
      out_d_nxt  = skid_d_r;
      skid_v_nxt = 1'b0;
    end else begin
      out_v_nxt = in_valid;
      out_d_nxt = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

endmodule
`default_nettype wire

FILE: sv/timed_level_pulse_sequencer.sv
// Each result word is registered in the output stage before it appears on the out_* ports.
// Throughput: one input word per cycle while in_stall is low; in_stall is high only while two result
// words are waiting in the output stage, and drops once the output takes one.
// Head entry comes from the entry RAM's registered read port with forwarding.
// Reset: rst_n synchronous active low; clears pointers, counters and control.
// The entry RAM is not cleared; no clearing pass is needed.
`default_nettype none
module timed_level_pulse_sequencer
  import tlps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PTR_W       = $clog2(QUEUE_DEPTH),
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [PRESC_W-1:0] cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_mode,
  input  wire logic               in_level,
  input  wire logic [DUR_W-1:0]   in_duration,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_pin_level,
  output logic                    out_active,
  output logic                    out_dropped,
  output logic [CNT_W-1:0]        out_fill_count
);

  localparam int RES_W = 3 + CNT_W;

  logic [PRESC_W-1:0] presc_div_r;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               running_r, running_nxt;
  logic               pin_r, pin_nxt;
  logic [DUR_W-1:0]   tick_cnt_r, tick_cnt_nxt;
  logic [PRESC_W-1:0] presc_cnt_r, presc_cnt_nxt;
  logic [DUR_W-1:0]   reload_r, reload_nxt;

  entry_t head_r;
  entry_t in_entry;
  entry_t step_entry;

  logic accept, is_push, full, empty, do_write, push_step, tick_run;
  logic presc_wrap, tick_step, step, pop, dropped;
  logic [RES_W-1:0] res_data, res_q;

  assign accept    = in_valid && !in_stall;
  assign is_push   = accept && (mode_t'(in_mode) == MODE_PUSH);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_write  = is_push && !full;
  assign dropped   = is_push && full;
  assign push_step = do_write && !running_r;
  assign tick_run  = accept && (mode_t'(in_mode) == MODE_TICK) && running_r;
  assign presc_wrap = (presc_cnt_r >= presc_div_r);
  assign tick_step = tick_run && presc_wrap && (tick_cnt_r >= reload_r);
  assign step      = push_step || tick_step;
  assign pop       = push_step || (tick_step && !empty);

  assign in_entry.level    = in_level;
  assign in_entry.duration = in_duration;

  always_comb begin
    if (!empty) begin
      step_entry = head_r;
    end else if (push_step) begin
      step_entry = in_entry;
    end else begin
      step_entry = '0;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (do_write) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (do_write && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !do_write) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    running_nxt   = running_r;
    pin_nxt       = pin_r;
    reload_nxt    = reload_r;
    tick_cnt_nxt  = tick_cnt_r;
    presc_cnt_nxt = presc_cnt_r;
    if (step) begin
      pin_nxt       = step_entry.level;
      reload_nxt    = step_entry.duration;
      tick_cnt_nxt  = '0;
      presc_cnt_nxt = '0;
      running_nxt   = (step_entry.duration != '0);
    end else if (tick_run) begin
      if (presc_wrap) begin
        presc_cnt_nxt = '0;
        tick_cnt_nxt  = tick_cnt_r + 1'b1;
      end else begin
        presc_cnt_nxt = presc_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_div_r <= '0;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      running_r   <= 1'b0;
      pin_r       <= 1'b0;
      tick_cnt_r  <= '0;
      presc_cnt_r <= '0;
      reload_r    <= '0;
    end else begin
      if (cfg_we) begin
        presc_div_r <= cfg_wdata;
      end
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      running_r   <= running_nxt;
      pin_r       <= pin_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      presc_cnt_r <= presc_cnt_nxt;
      reload_r    <= reload_nxt;
    end
  end

  tlps_entry_ram #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (PTR_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (do_write),
    .wr_addr   (wr_ptr_r),
    .wr_data   (in_entry),
    .rd_addr   (rd_ptr_nxt),
    .rd_data_r (head_r)
  );

  assign res_data = {pin_nxt, running_nxt, dropped, count_nxt};

  tlps_out_buf #(
    .WIDTH (RES_W)
  ) u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_stall  (in_stall),
    .in_data   (res_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (res_q)
  );

  assign {out_pin_level, out_active, out_dropped, out_fill_count} = res_q;

endmodule
`default_nettype wire

FILE: sv/tlps_checker.sv
`default_nettype none
module tlps_checker
  import tlps_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire logic             out_pin_level,
  input wire logic             out_active,
  input wire logic             out_dropped,
  input wire logic [CNT_W-1:0] out_fill_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pin_level) && $stable(out_active)
      && $stable(out_dropped) && $stable(out_fill_count))
    else $error("stalled result word changed");

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_fill_count == CNT_W'(QUEUE_DEPTH))
    else $error("drop reported with queue not full");

  // an idle sequencer never holds a full queue
  a_drop_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_active)
    else $error("drop reported while idle");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count out of range");

endmodule

bind timed_level_pulse_sequencer tlps_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (.*);
`default_nettype wire
